FILE: hw/rtl/rkcd_pkg.sv
package rkcd_pkg;

	// width of one store word and of one span header field
	localparam int WORD_W  = 16;
	localparam int COUNT_W = 8;

	// source of the result loaded into the result register
	typedef enum logic [1:0] {
		RES_ZERO = 2'd0,
		RES_BASE = 2'd1,
		RES_ERR  = 2'd2,
		RES_CALC = 2'd3
	} res_sel_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic     latch;      // capture the input item
		logic     mem_write;  // store the latched word
		logic     hdr_read;   // read the header at the span pointer
		logic     hdr_step;   // evaluate a header, skip the span or select values
		logic     val1_read;  // read the first value
		logic     val1_take;  // capture first value, read the second
		logic     val2_take;  // capture second value
		logic     mul_blend;  // difference times blend fraction
		logic     add_blend;  // form the blended value
		logic     mul_scale;  // blended value times scale
		logic     res_set;    // load the result register
		res_sel_t res_sel;
		logic     out_load;   // move the result into the output register
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic kind;       // 1 for a query
		logic has_data;
		logic start_oob;  // channel start past the store
		logic skip;       // current header does not reach the frame
		logic next_oob;   // next span header past the store
		logic a1_oob;
		logic a2_oob;
		logic two;        // two values are blended
	} dp_status_t;

endpackage

FILE: hw/rtl/rkcd_ram.sv
module rkcd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/rkcd_ctrl.sv
module rkcd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  rkcd_pkg::dp_status_t status,
	output rkcd_pkg::dp_cmd_t    cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_START = 11'b000_0000_0010,
		S_HDR   = 11'b000_0000_0100,
		S_RD1   = 11'b000_0000_1000,
		S_RD2   = 11'b000_0001_0000,
		S_V2    = 11'b000_0010_0000,
		S_MUL1  = 11'b000_0100_0000,
		S_BLEND = 11'b000_1000_0000,
		S_MUL2  = 11'b001_0000_0000,
		S_SUM   = 11'b010_0000_0000,
		S_FIN   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// next state and datapath commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.res_sel = rkcd_pkg::RES_ZERO;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_START;
				end
			end
			S_START: begin
				priority if (!status.kind) begin
					cmd.mem_write = 1'b1;
					cmd.res_set   = 1'b1;
					cmd.res_sel   = rkcd_pkg::RES_ZERO;
					state_d       = S_FIN;
				end else if (!status.has_data) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = rkcd_pkg::RES_BASE;
					state_d     = S_FIN;
				end else if (status.start_oob) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = rkcd_pkg::RES_ERR;
					state_d     = S_FIN;
				end else begin
					cmd.hdr_read = 1'b1;
					state_d      = S_HDR;
				end
			end
			S_HDR: begin
				cmd.hdr_step = 1'b1;
				priority if (status.skip && status.next_oob) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = rkcd_pkg::RES_ERR;
					state_d     = S_FIN;
				end else if (!status.skip) begin
					state_d = S_RD1;
				end else begin
					state_d = S_HDR;
				end
			end
			S_RD1: begin
				if (status.a1_oob) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = rkcd_pkg::RES_ERR;
					state_d     = S_FIN;
				end else begin
					cmd.val1_read = 1'b1;
					state_d       = S_RD2;
				end
			end
			S_RD2: begin
				cmd.val1_take = 1'b1;
				priority if (status.two && status.a2_oob) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = rkcd_pkg::RES_ERR;
					state_d     = S_FIN;
				end else if (status.two) begin
					state_d = S_V2;
				end else begin
					state_d = S_MUL1;
				end
			end
			S_V2: begin
				cmd.val2_take = 1'b1;
				state_d       = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul_blend = 1'b1;
				state_d       = S_BLEND;
			end
			S_BLEND: begin
				cmd.add_blend = 1'b1;
				state_d       = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_scale = 1'b1;
				state_d       = S_SUM;
			end
			S_SUM: begin
				cmd.res_set = 1'b1;
				cmd.res_sel = rkcd_pkg::RES_CALC;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/rkcd_dp.sv
module rkcd_dp #(
	parameter int STORE_WORDS = 4096
) (
	input  logic                     clk,
	input  rkcd_pkg::dp_cmd_t        cmd,
	output rkcd_pkg::dp_status_t     status,
	input  logic                     kind,
	input  logic [11:0]              address,
	input  logic [15:0]              word_data,
	input  logic                     has_data,
	input  logic [15:0]              frame,
	input  logic [15:0]              blend,
	input  logic signed [31:0]       rest_value,
	input  logic signed [31:0]       scale,
	input  logic signed [31:0]       controller_offset,
	output logic signed [47:0]       position,
	output logic                     error
);

	localparam int AW    = $clog2(STORE_WORDS);
	localparam int SPAN  = (STORE_WORDS > 4096) ? STORE_WORDS : 4096;
	localparam int PW    = $clog2(SPAN + 512);
	localparam logic [PW-1:0] LIMIT = PW'(STORE_WORDS);

	// latched item
	logic                     kind_q;
	logic                     has_q;
	logic [PW-1:0]            p_q;
	logic [15:0]              j_q;
	logic [15:0]              bl_q;
	logic [15:0]              wdata_q;
	logic signed [31:0]       scale_q;
	logic signed [32:0]       base_q;

	// span selection
	logic [PW-1:0]            a1_q, a2_q;
	logic                     two_q;
	logic [15:0]              v1_q, v2_q;
	logic signed [63:0]       prod_q;
	logic signed [31:0]       val_q;
	logic signed [47:0]       res_pos_q, pos_q;
	logic                     res_err_q, err_q;

	logic [rkcd_pkg::WORD_W-1:0]  rdata;
	logic [AW-1:0]                raddr;
	logic                         we;
	logic [rkcd_pkg::COUNT_W-1:0] hv, ht;
	logic [15:0]              j_eff;
	logic [16:0]              j_inc;
	logic                     in_vals, skip;
	logic [PW-1:0]            p_skip, a1_n, a2_n;
	logic                     two_n;
	logic [16:0]              diff;
	logic signed [31:0]       ma, mb;
	logic signed [63:0]       rnd, shifted;
	logic signed [47:0]       calc;

	// header evaluation
	always_comb begin
		hv      = rdata[7:0];
		ht      = rdata[15:8];
		j_eff   = (ht < hv) ? 16'h0 : j_q;
		j_inc   = {1'b0, j_eff} + 17'd1;
		skip    = ({8'h0, ht} <= j_eff);
		in_vals = ({8'h0, hv} > j_eff);
		p_skip  = p_q + PW'(hv) + PW'(1);
		if (in_vals) begin
			a1_n  = p_q + PW'(j_eff[7:0]) + PW'(1);
			a2_n  = p_q + PW'(j_eff[7:0]) + PW'(2);
			two_n = ({9'h0, hv} > j_inc);
		end else begin
			a1_n  = p_q + PW'(hv);
			a2_n  = p_q + PW'(hv) + PW'(2);
			two_n = ({9'h0, ht} <= j_inc);
		end
	end

	assign status.kind      = kind_q;
	assign status.has_data  = has_q;
	assign status.start_oob = (p_q >= LIMIT);
	assign status.skip      = skip;
	assign status.next_oob  = (p_skip >= LIMIT);
	assign status.a1_oob    = (a1_q >= LIMIT);
	assign status.a2_oob    = (a2_q >= LIMIT);
	assign status.two       = two_q;

	// store read address
	always_comb begin
		priority if (cmd.hdr_read) begin
			raddr = p_q[AW-1:0];
		end else if (cmd.hdr_step) begin
			raddr = p_skip[AW-1:0];
		end else if (cmd.val1_read) begin
			raddr = a1_q[AW-1:0];
		end else if (cmd.val1_take) begin
			raddr = a2_q[AW-1:0];
		end else begin
			raddr = p_q[AW-1:0];
		end
	end

	assign we = cmd.mem_write && (p_q < LIMIT);

	rkcd_ram #(
		.WIDTH(rkcd_pkg::WORD_W),
		.DEPTH(STORE_WORDS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(p_q[AW-1:0]),
		.wdata(wdata_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	// shared multiplier operands
	always_comb begin
		diff = {v2_q[15], v2_q} - {v1_q[15], v1_q};
		if (cmd.mul_scale) begin
			ma = val_q;
			mb = scale_q;
		end else begin
			ma = {{15{diff[16]}}, diff};
			mb = {16'h0, bl_q};
		end
	end

	// round to q.16 and add rest plus offset
	always_comb begin
		rnd     = prod_q + 64'sd32768;
		shifted = rnd >>> 16;
		calc    = shifted[47:0] + {{15{base_q[32]}}, base_q};
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q  <= kind;
			has_q   <= has_data;
			p_q     <= PW'(address);
			j_q     <= frame;
			bl_q    <= blend;
			wdata_q <= word_data;
			scale_q <= scale;
			base_q  <= {rest_value[31], rest_value}
				+ {controller_offset[31], controller_offset};
		end
		if (cmd.hdr_step) begin
			if (skip) begin
				j_q <= j_eff - {8'h0, ht};
				p_q <= p_skip;
			end else begin
				a1_q  <= a1_n;
				a2_q  <= a2_n;
				two_q <= two_n;
			end
		end
		if (cmd.val1_take) begin
			v1_q <= rdata;
			v2_q <= rdata;
		end
		if (cmd.val2_take) begin
			v2_q <= rdata;
		end
		if (cmd.mul_blend || cmd.mul_scale) begin
			prod_q <= 64'(ma) * 64'(mb);
		end
		if (cmd.add_blend) begin
			val_q <= {v1_q, 16'h0} + prod_q[31:0];
		end
		if (cmd.res_set) begin
			unique case (cmd.res_sel)
				rkcd_pkg::RES_ZERO: begin
					res_pos_q <= '0;
					res_err_q <= 1'b0;
				end
				rkcd_pkg::RES_BASE: begin
					res_pos_q <= {{15{base_q[32]}}, base_q};
					res_err_q <= 1'b0;
				end
				rkcd_pkg::RES_ERR: begin
					res_pos_q <= '0;
					res_err_q <= 1'b1;
				end
				rkcd_pkg::RES_CALC: begin
					res_pos_q <= calc;
					res_err_q <= 1'b0;
				end
				default: begin
					res_pos_q <= '0;
					res_err_q <= 1'b0;
				end
			endcase
		end
		if (cmd.out_load) begin
			pos_q <= res_pos_q;
			err_q <= res_err_q;
		end
	end

	assign position = pos_q;
	assign error    = err_q;

endmodule

FILE: hw/rtl/rle_keyframe_channel_decode.sv
// Run-length keyframe channel decoder. Items with kind 0 write one 16-bit word
// into the store; items with kind 1 walk the spans of a channel from its start
// word to the requested frame, fetch one or two values, blend them by the Q0.16
// fraction, scale them and add the rest value and controller offset, giving a
// signed Q32.16 position. A walk that reads past the store end flags error and
// returns zero. One item is in work at a time. An animated query reads the span
// headers one per cycle through the single read port of the store, followed by
// the value reads and the shared multiplier used twice. A walk that runs past
// the store end stops there. The output register lets the next item be
// transferred while the last result waits. No clearing pass follows reset.
module rle_keyframe_channel_decode #(
	parameter int STORE_WORDS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [11:0]        address,
	input  logic [15:0]        word_data,
	input  logic               has_data,
	input  logic [15:0]        frame,
	input  logic [15:0]        blend,
	input  logic signed [31:0] rest_value,
	input  logic signed [31:0] scale,
	input  logic signed [31:0] controller_offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] position,
	output logic               error
);

	rkcd_pkg::dp_cmd_t    cmd;
	rkcd_pkg::dp_status_t status;

	// sequencer
	rkcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// store, span walk and arithmetic
	rkcd_dp #(
		.STORE_WORDS(STORE_WORDS)
	) u_dp (
		.clk              (clk),
		.cmd              (cmd),
		.status           (status),
		.kind             (kind),
		.address          (address),
		.word_data        (word_data),
		.has_data         (has_data),
		.frame            (frame),
		.blend            (blend),
		.rest_value       (rest_value),
		.scale            (scale),
		.controller_offset(controller_offset),
		.position         (position),
		.error            (error)
	);

endmodule
